### hdl/dhf_pkg.sv
// ----------------------------------------------------------------------------
// dhf_pkg
// Shared types and constants for the 5x5 depth hole-fill mode filter.
// ----------------------------------------------------------------------------
package dhf_pkg;

	localparam int MAX_W  = 640;
	localparam int MAX_H  = 480;
	localparam int DW     = 16;
	localparam int COL_W  = $clog2(MAX_W + 1);
	localparam int ROW_W  = $clog2(MAX_H + 5);
	localparam int WARM_W = $clog2(2 * MAX_W + 3);
	localparam int NB     = 24;
	localparam int CNT_W  = 5;
	localparam int NGRP   = 6;
	localparam int GSZ    = 4;
	localparam int MEM_W  = 4 * DW;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 10;

	// register indexes on the config port
	localparam logic [CFG_IW-1:0] CFG_INNER_THR = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_OUTER_THR = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_WIDTH     = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_HEIGHT    = 2'd3;

	// neighbour slots that fall in the inner 3x3 ring (row-major, centre skipped)
	localparam logic [NB-1:0] INNER_MASK = 24'h0399C0;

	typedef struct packed {
		logic [DW-1:0] depth;
		logic          flush;
	} pix_t;

	typedef struct packed {
		logic [DW-1:0] output_depth;
		logic          last_of_frame;
	} res_t;

	typedef struct packed {
		logic emit;
		logic last;
	} ctl_t;

	typedef logic [NB-1:0][DW-1:0] nbr_t;

endpackage

### hdl/dhf_line_mem.sv
// ----------------------------------------------------------------------------
// dhf_line_mem
// Four-row line store, one word per column, registered read.
// ----------------------------------------------------------------------------
module dhf_line_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [dhf_pkg::COL_W-1:0]  waddr,
	input  logic [dhf_pkg::MEM_W-1:0]  wdata,
	input  logic                       re,
	input  logic [dhf_pkg::COL_W-1:0]  raddr,
	output logic [dhf_pkg::MEM_W-1:0]  rdata
);
	import dhf_pkg::*;

	logic [MEM_W-1:0] mem [MAX_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/dhf_mode.sv
// ----------------------------------------------------------------------------
// dhf_mode
// Mode of the 24 neighbours: match counts, grouped argmax, final pick.
// ----------------------------------------------------------------------------
module dhf_mode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  dhf_pkg::ctl_t         ctl_in,
	input  dhf_pkg::nbr_t         vals,
	input  logic [dhf_pkg::DW-1:0] centre,
	input  logic [3:0]            inner_thr,
	input  logic [4:0]            outer_thr,
	output dhf_pkg::ctl_t         ctl_out,
	output logic [dhf_pkg::DW-1:0] result
);
	import dhf_pkg::*;

	// s4: match counts
	ctl_t             ctl_s4;
	nbr_t             vals_s4;
	logic [CNT_W-1:0] cnt_s4 [NB];
	logic [DW-1:0]    centre_s4;
	logic             trig_s4;

	logic [CNT_W-1:0] cnt_d [NB];
	logic             trig_d;

	always_comb begin
		logic [3:0] n_in;
		logic [4:0] n_out;
		n_in  = '0;
		n_out = '0;
		for (int k = 0; k < NB; k++) begin
			cnt_d[k] = '0;
			for (int j = 0; j < NB; j++) begin
				cnt_d[k] = cnt_d[k] + CNT_W'(vals[j] == vals[k] && vals[k] != '0);
			end
			if (vals[k] != '0) begin
				if (INNER_MASK[k]) n_in = n_in + 4'd1;
				else               n_out = n_out + 5'd1;
			end
		end
		trig_d = (n_in >= inner_thr) || (n_out >= outer_thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s4 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vals_s4   <= vals;
			cnt_s4    <= cnt_d;
			centre_s4 <= centre;
			trig_s4   <= trig_d;
		end
	end

	// s5: best of each group of four, first wins ties
	ctl_t             ctl_s5;
	logic [DW-1:0]    gval_s5 [NGRP];
	logic [CNT_W-1:0] gcnt_s5 [NGRP];
	logic [DW-1:0]    centre_s5;
	logic             trig_s5;

	logic [DW-1:0]    gval_d [NGRP];
	logic [CNT_W-1:0] gcnt_d [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			gval_d[g] = '0;
			gcnt_d[g] = '0;
			for (int i = 0; i < GSZ; i++) begin
				if (cnt_s4[g*GSZ+i] > gcnt_d[g]) begin
					gcnt_d[g] = cnt_s4[g*GSZ+i];
					gval_d[g] = vals_s4[g*GSZ+i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gval_s5   <= gval_d;
			gcnt_s5   <= gcnt_d;
			centre_s5 <= centre_s4;
			trig_s5   <= trig_s4;
		end
	end

	// final pick across groups
	always_comb begin
		logic [CNT_W-1:0] best;
		logic [DW-1:0]    pick;
		best = '0;
		pick = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (gcnt_s5[g] > best) begin
				best = gcnt_s5[g];
				pick = gval_s5[g];
			end
		end
		if (centre_s5 != '0) result = centre_s5;
		else if (trig_s5)    result = pick;
		else                 result = '0;
	end

	assign ctl_out = ctl_s5;

endmodule

### hdl/depth_hole_fill_mode_5x5.sv
// ----------------------------------------------------------------------------
// depth_hole_fill_mode_5x5
// Streaming 5x5 mode filter that fills zero depth pixels.
// ----------------------------------------------------------------------------
// Usage:
//   pix channel: one raster-order depth pixel per beat (pix_valid/pix_stall).
//     After the frame's W*H pixels, send 2*W+2 drain beats (flush=1) to push
//     out the tail. A flush beat at frame start is dropped silently.
//   res channel: one filtered pixel per beat, last_of_frame on the final one.
//   cfg channel: thresholds and frame size; always ready. W and H are sampled
//     on the first pixel of a frame, so writes land on the next frame.
// Throughput: one beat per cycle, sustained while res_stall does not hold the pipeline.
// Pipeline: after the beat that completes a pixel's window (the pixel 2 rows
//   + 2 columns later), its result passes through line-store read, window shift,
//   masking, match count and two argmax levels into the output register.
// Stall: res_stall freezes the whole pipeline once the output register is
//   full; pix_stall then rises. Nothing is dropped or repeated.
// Reset: pipeline empties, counters clear, registers return to 2/5/640/480.
//   The line store is not cleared; unwritten rows are masked off by position.
// ----------------------------------------------------------------------------
module depth_hole_fill_mode_5x5 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  dhf_pkg::pix_t               pix,
	output logic                        res_valid,
	input  logic                        res_stall,
	output dhf_pkg::res_t               res,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dhf_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [dhf_pkg::CFG_DW-1:0]  cfg_data
);
	import dhf_pkg::*;

	// config registers
	logic [3:0]       inner_thr_q;
	logic [4:0]       outer_thr_q;
	logic [9:0]       width_q;
	logic [8:0]       height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_thr_q <= 4'd2;
			outer_thr_q <= 5'd5;
			width_q     <= 10'd640;
			height_q    <= 9'd480;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INNER_THR: inner_thr_q <= cfg_data[3:0];
				CFG_OUTER_THR: outer_thr_q <= cfg_data[4:0];
				CFG_WIDTH:     width_q     <= cfg_data[9:0];
				CFG_HEIGHT:    height_q    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// global advance: output register empty or being drained
	logic res_v_q;
	logic adv;
	assign adv       = !res_v_q || !res_stall;
	assign pix_stall = !adv;

	logic take;
	assign take = pix_valid && adv;

	// ---------------- s0: position tracking ----------------
	logic              act_q;
	logic [COL_W-1:0]  cur_w_q;
	logic [ROW_W-1:0]  cur_h_q;
	logic [COL_W-1:0]  ic_q;
	logic [ROW_W-1:0]  ir_q;
	logic [WARM_W-1:0] warm_q;
	logic [COL_W-1:0]  oc_q;
	logic [ROW_W-1:0]  or_q;

	logic              start, ignore, enter;
	logic [COL_W-1:0]  w_eff, ic_cur, oc_cur, ic_nxt;
	logic [ROW_W-1:0]  h_eff, ir_cur, or_cur;
	logic [WARM_W-1:0] warm_cur;
	logic              emit, last;
	logic [DW-1:0]     sample;
	logic [4:0]        rv, cv;

	always_comb begin
		start  = !act_q;
		ignore = start && pix.flush;
		enter  = take && !ignore;

		if (!start)                   w_eff = cur_w_q;
		else if (width_q == '0)       w_eff = COL_W'(1);
		else if (width_q > 10'(MAX_W)) w_eff = COL_W'(MAX_W);
		else                          w_eff = COL_W'(width_q);

		if (!start)                   h_eff = cur_h_q;
		else if (height_q == '0)      h_eff = ROW_W'(1);
		else if (height_q > 9'(MAX_H)) h_eff = ROW_W'(MAX_H);
		else                          h_eff = ROW_W'(height_q);

		ic_cur   = start ? '0 : ic_q;
		ir_cur   = start ? '0 : ir_q;
		oc_cur   = start ? '0 : oc_q;
		or_cur   = start ? '0 : or_q;
		warm_cur = start ? ({1'b0, w_eff} << 1) + WARM_W'(2) : warm_q;

		sample = (ir_cur < h_eff && !pix.flush) ? pix.depth : '0;
		emit   = (warm_cur == '0);
		last   = emit && (oc_cur == w_eff - COL_W'(1)) && (or_cur == h_eff - ROW_W'(1));
		ic_nxt = ic_cur + COL_W'(1);

		// in-frame bits for window rows/cols around the centre
		rv[0] = (or_cur >= ROW_W'(2));
		rv[1] = (or_cur >= ROW_W'(1));
		rv[2] = 1'b1;
		rv[3] = ({1'b0, or_cur} + (ROW_W+1)'(1)) < {1'b0, h_eff};
		rv[4] = ({1'b0, or_cur} + (ROW_W+1)'(2)) < {1'b0, h_eff};
		cv[0] = (oc_cur >= COL_W'(2));
		cv[1] = (oc_cur >= COL_W'(1));
		cv[2] = 1'b1;
		cv[3] = ({1'b0, oc_cur} + (COL_W+1)'(1)) < {1'b0, w_eff};
		cv[4] = ({1'b0, oc_cur} + (COL_W+1)'(2)) < {1'b0, w_eff};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			cur_w_q <= COL_W'(MAX_W);
			cur_h_q <= ROW_W'(MAX_H);
			ic_q    <= '0;
			ir_q    <= '0;
			warm_q  <= '0;
			oc_q    <= '0;
			or_q    <= '0;
		end else if (enter) begin
			act_q   <= !last;
			cur_w_q <= w_eff;
			cur_h_q <= h_eff;
			if (ic_nxt == w_eff) begin
				ic_q <= '0;
				ir_q <= ir_cur + ROW_W'(1);
			end else begin
				ic_q <= ic_nxt;
				ir_q <= ir_cur;
			end
			warm_q <= emit ? warm_cur : warm_cur - WARM_W'(1);
			if (emit && oc_cur + COL_W'(1) == w_eff) begin
				oc_q <= '0;
				or_q <= or_cur + ROW_W'(1);
			end else if (emit) begin
				oc_q <= oc_cur + COL_W'(1);
				or_q <= or_cur;
			end else begin
				oc_q <= oc_cur;
				or_q <= or_cur;
			end
		end
	end

	// ---------------- s1: line store read / write ----------------
	logic             v_s1;
	ctl_t             ctl_s1;
	logic [DW-1:0]    sample_s1;
	logic [COL_W-1:0] ic_s1;
	logic [4:0]       rv_s1, cv_s1;
	logic             fwd_s1;
	logic [MEM_W-1:0] fwd_word_s1;

	logic [MEM_W-1:0] mem_rd;
	logic [MEM_W-1:0] rows_s1;
	logic [MEM_W-1:0] wr_word;

	// word layout: [15:0] one row back ... [63:48] four rows back
	assign rows_s1 = fwd_s1 ? fwd_word_s1 : mem_rd;
	assign wr_word = {rows_s1[MEM_W-DW-1:0], sample_s1};

	dhf_line_mem u_line_mem (
		.clk   (clk),
		.we    (v_s1 && adv),
		.waddr (ic_s1),
		.wdata (wr_word),
		.re    (adv),
		.raddr (ic_cur),
		.rdata (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ctl_s1 <= '0;
		end else if (adv) begin
			v_s1        <= enter;
			ctl_s1.emit <= enter && emit;
			ctl_s1.last <= last;
		end
	end

	// same-column back-to-back beats (narrow frames) see the write in flight
	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1   <= sample;
			ic_s1       <= ic_cur;
			rv_s1       <= rv;
			cv_s1       <= cv;
			fwd_s1      <= v_s1 && (ic_s1 == ic_cur);
			fwd_word_s1 <= wr_word;
		end
	end

	// ---------------- s2: 5x5 window ----------------
	ctl_t          ctl_s2;
	logic [4:0]    rv_s2, cv_s2;
	logic [DW-1:0] win_q [5][5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rv_s2 <= rv_s1;
			cv_s2 <= cv_s1;
		end
	end

	// window shifts only on real beats; newest column at x = 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < 5; y++) begin
				for (int x = 0; x < 5; x++) begin
					win_q[y][x] <= '0;
				end
			end
		end else if (adv && v_s1) begin
			for (int y = 0; y < 5; y++) begin
				for (int x = 0; x < 4; x++) begin
					win_q[y][x] <= win_q[y][x+1];
				end
			end
			win_q[4][4] <= sample_s1;
			win_q[3][4] <= rows_s1[DW-1:0];
			win_q[2][4] <= rows_s1[2*DW-1:DW];
			win_q[1][4] <= rows_s1[3*DW-1:2*DW];
			win_q[0][4] <= rows_s1[4*DW-1:3*DW];
		end
	end

	// ---------------- s3: out-of-frame masking ----------------
	ctl_t          ctl_s3;
	nbr_t          vals_s3;
	logic [DW-1:0] centre_s3;
	nbr_t          vals_d;

	always_comb begin
		for (int y = 0; y < 5; y++) begin
			for (int x = 0; x < 5; x++) begin
				if (y * 5 + x < 12) begin
					vals_d[y*5+x] = (rv_s2[y] && cv_s2[x]) ? win_q[y][x] : '0;
				end else if (y * 5 + x > 12) begin
					vals_d[y*5+x-1] = (rv_s2[y] && cv_s2[x]) ? win_q[y][x] : '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vals_s3   <= vals_d;
			centre_s3 <= win_q[2][2];
		end
	end

	// ---------------- s4, s5: mode ----------------
	ctl_t          ctl_s5;
	logic [DW-1:0] result_s5;

	dhf_mode u_mode (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_in    (ctl_s3),
		.vals      (vals_s3),
		.centre    (centre_s3),
		.inner_thr (inner_thr_q),
		.outer_thr (outer_thr_q),
		.ctl_out   (ctl_s5),
		.result    (result_s5)
	);

	// ---------------- output register ----------------
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (adv) begin
			res_v_q <= ctl_s5.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.output_depth  <= result_s5;
			res_q.last_of_frame <= ctl_s5.last;
		end
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule
